// ----- src/imu_afp_pkg.sv -----
// Shared types and constants for the IMU angle frame parser.
`default_nettype none

package imu_afp_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 11;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam logic [POS_W-1:0] IDLE_POS     = POS_W'(0);
    localparam logic [POS_W-1:0] FIRST_POS    = POS_W'(1);
    localparam logic [POS_W-1:0] TYPE_POS     = POS_W'(1);
    localparam logic [POS_W-1:0] YAW_LOW_POS  = POS_W'(6);
    localparam logic [POS_W-1:0] YAW_HIGH_POS = POS_W'(7);
    localparam logic [POS_W-1:0] SUM_POS      = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] HEADER_BYTE       = 8'h55;
    localparam logic [7:0] ANGLE_TYPE_RESET  = 8'h53;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_GOOD     = 2'd0;
    localparam status_t STATUS_BAD_TYPE = 2'd1;
    localparam status_t STATUS_BAD_SUM  = 2'd2;

endpackage : imu_afp_pkg

`default_nettype wire

// ----- src/imu_afp_if.sv -----
// Channel interfaces: received bytes, frame results and the type register write.
`default_nettype none

interface imu_afp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : imu_afp_byte_if

interface imu_afp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] angle_frame_type;

    modport source (output valid, output angle_frame_type, input ready);
    modport sink   (input valid, input angle_frame_type, output ready);
endinterface : imu_afp_cfg_if

interface imu_afp_res_if
    import imu_afp_pkg::*;
();
    logic               valid;
    logic               ready;
    status_t            frame_status;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] yaw_degrees_q7;
    logic [15:0]        good_frame_count;

    modport source (
        output valid, output frame_status, output yaw_raw,
        output yaw_degrees_q7, output good_frame_count, input ready
    );
    modport sink (
        input valid, input frame_status, input yaw_raw,
        input yaw_degrees_q7, input good_frame_count, output ready
    );
endinterface : imu_afp_res_if

`default_nettype wire

// ----- src/imu_angle_frame_parser_top.sv -----
// IMU angle frame parser: byte stream in, one status/yaw result per 11-byte frame out.
`default_nettype none

// Takes one received byte per transfer on rx and hunts for the 0x55 header
// while idle; bytes other than the header are dropped silently. After a
// header it collects ten more bytes (type in byte 1, yaw low/high in bytes
// 6/7, checksum in byte 10), with no resync on a header seen mid-frame. On
// the checksum byte it issues one result transfer on res: frame_status
// (0 good, 1 wrong type, 2 checksum mismatch; a wrong type wins), the raw
// signed yaw, yaw in 1/128 degree (raw*45 >>> 6, floor) and the wrapping
// count of good frames, this one included if good. A byte is taken every cycle:
// the whole per-byte update is one register stage, and the result sits in
// an output register so a new frame can be collected while it waits. Only
// a checksum byte can stall, and only while that register is full and not
// being drained. The expected type byte (reset 0x53) is written through
// cfg, which is always ready; write it only while no frame is in flight.
module imu_angle_frame_parser_top
    import imu_afp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    imu_afp_byte_if.sink       rx,
    imu_afp_cfg_if.sink        cfg,
    imu_afp_res_if.source      res
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [7:0]       angle_type_reg;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       sum_reg,      sum_next;
    logic [7:0]       type_reg,     type_next;
    logic [7:0]       yaw_lo_reg,   yaw_lo_next;
    logic [7:0]       yaw_hi_reg,   yaw_hi_next;
    logic [15:0]      good_reg,     good_next;
    logic             out_valid_reg, out_valid_next;

    status_t            status_reg;
    logic signed [15:0] yaw_raw_reg;
    logic signed [15:0] yaw_q7_reg;
    logic [15:0]        count_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic rx_xfer;
    logic res_xfer;
    logic last_byte;   // current byte is the checksum byte
    logic load;        // a result is captured this cycle

    // Positions past the checksum index are treated as the checksum byte.
    assign last_byte = (pos_reg >= SUM_POS);
    assign rx.ready  = !last_byte || !out_valid_reg || res.ready;
    assign rx_xfer   = rx.valid && rx.ready;
    assign res_xfer  = out_valid_reg && res.ready;
    assign load      = rx_xfer && last_byte;
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Frame checks and yaw scaling
    // ------------------------------------------------------------------
    status_t     status;
    logic [15:0] raw_bits;
    logic [21:0] raw_ext;
    logic [21:0] prod;

    always_comb
    begin
        if (type_reg != angle_type_reg)
        begin
            status = STATUS_BAD_TYPE;
        end
        else if (sum_reg != rx.rx_byte)
        begin
            status = STATUS_BAD_SUM;
        end
        else
        begin
            status = STATUS_GOOD;
        end
    end

    assign raw_bits = {yaw_hi_reg, yaw_lo_reg};
    assign raw_ext  = {{6{raw_bits[15]}}, raw_bits};
    // raw * 45 as shifts; bits [21:6] are the floor of the product / 64
    assign prod     = (raw_ext << 5) + (raw_ext << 3) + (raw_ext << 2) + raw_ext;

    // ------------------------------------------------------------------
    // Per-byte update
    // ------------------------------------------------------------------
    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        type_next      = type_reg;
        yaw_lo_next    = yaw_lo_reg;
        yaw_hi_next    = yaw_hi_reg;
        good_next      = good_reg;
        out_valid_next = out_valid_reg && !res_xfer;

        if (rx_xfer)
        begin
            if (pos_reg == IDLE_POS)
            begin
                if (rx.rx_byte == HEADER_BYTE)
                begin
                    sum_next = rx.rx_byte;
                    pos_next = FIRST_POS;
                end
            end
            else if (!last_byte)
            begin
                sum_next = sum_reg + rx.rx_byte;
                case (pos_reg)
                    TYPE_POS:     type_next   = rx.rx_byte;
                    YAW_LOW_POS:  yaw_lo_next = rx.rx_byte;
                    YAW_HIGH_POS: yaw_hi_next = rx.rx_byte;
                    default:      ;
                endcase
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                pos_next       = IDLE_POS;
                out_valid_next = 1'b1;
                if (status == STATUS_GOOD)
                begin
                    good_next = good_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_type_reg <= ANGLE_TYPE_RESET;
            pos_reg        <= IDLE_POS;
            sum_reg        <= '0;
            type_reg       <= '0;
            yaw_lo_reg     <= '0;
            yaw_hi_reg     <= '0;
            good_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                angle_type_reg <= cfg.angle_frame_type;
            end
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            type_reg      <= type_next;
            yaw_lo_reg    <= yaw_lo_next;
            yaw_hi_reg    <= yaw_hi_next;
            good_reg      <= good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded on the checksum byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= status;
            yaw_raw_reg <= raw_bits;
            yaw_q7_reg  <= prod[21:6];
            count_reg   <= good_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.frame_status     = status_reg;
    assign res.yaw_raw          = yaw_raw_reg;
    assign res.yaw_degrees_q7   = yaw_q7_reg;
    assign res.good_frame_count = count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= SUM_POS)
        else $error("byte position past checksum index");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("checksum byte did not produce a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || res_xfer))
        else $error("pending result overwritten");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (good_reg != $past(good_reg)) |->
            ($past(load) && (good_reg == $past(good_reg) + 16'd1)))
        else $error("good frame count changed outside a good frame");

    a_good_status: assert property (@(posedge clk) disable iff (!rst_n)
        load && (status == STATUS_GOOD) |=> (count_reg == good_reg))
        else $error("reported count differs from the running count");
`endif

endmodule : imu_angle_frame_parser_top

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for the IMU angle frame parser: byte stream stimulus with frame result checking.
`timescale 1ns / 100ps

module tb
    import imu_afp_pkg::*;
();

    // No transfer on any channel for this many cycles ends the run.
    // Legit quiet spans are the reset, a short settle after each phase
    // and random gaps/stalls, so this is far above them.
    localparam int QUIET_LIMIT   = 2000;
    // Settle time before a register write or the final verdict. The parser
    // holds the result one register stage after the checksum byte.
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PCT      = 13;
    localparam int PHASE_BYTES   = 80;
    localparam int PHASE_FRAMES  = 8;

    // One frame result as the parser reports it.
    typedef struct packed {
        status_t            status;
        logic signed [15:0] yaw_raw;
        logic signed [15:0] yaw_q7;
        logic [15:0]        good_count;
    } frame_result_t;

    // Tracks the parser's frame state byte by byte and queues the result
    // that each checksum byte is due to produce.
    class frame_checker;
        logic [7:0]       angle_type;
        logic [POS_W-1:0] pos;
        logic [7:0]       running_total;
        logic [7:0]       cap_type;
        logic [7:0]       yaw_lo;
        logic [7:0]       yaw_hi;
        logic [15:0]      good_cnt;
        frame_result_t    pending_frames[$];
        int               frames_predicted;
        int               errors;

        function new();
            angle_type       = ANGLE_TYPE_RESET;
            pos              = IDLE_POS;
            running_total    = 8'h00;
            cap_type         = 8'h00;
            yaw_lo           = 8'h00;
            yaw_hi           = 8'h00;
            good_cnt         = 16'h0000;
            frames_predicted = 0;
            errors           = 0;
        endfunction

        function void set_angle_type(logic [7:0] t);
            angle_type = t;
        endfunction

        function int frames_outstanding();
            return pending_frames.size();
        endfunction

        function void note_byte(logic [7:0] b);
            frame_result_t      r;
            logic [15:0]        raw_bits;
            logic signed [31:0] scaled;
            if (pos == IDLE_POS)
            begin
                // hunting for the header; anything else is dropped
                if (b == HEADER_BYTE)
                begin
                    running_total = b;
                    pos           = FIRST_POS;
                end
                return;
            end
            if (pos < SUM_POS)
            begin
                running_total = running_total + b;
                if (pos == TYPE_POS)
                    cap_type = b;
                else if (pos == YAW_LOW_POS)
                    yaw_lo = b;
                else if (pos == YAW_HIGH_POS)
                    yaw_hi = b;
                pos = pos + POS_W'(1);
                return;
            end
            // checksum byte: wrong type wins over a bad sum
            pos = IDLE_POS;
            if (cap_type != angle_type)
                r.status = STATUS_BAD_TYPE;
            else if (running_total != b)
                r.status = STATUS_BAD_SUM;
            else
            begin
                r.status = STATUS_GOOD;
                good_cnt = good_cnt + 16'd1;
            end
            raw_bits     = {yaw_hi, yaw_lo};
            scaled       = $signed(raw_bits) * 32'sd45;
            r.yaw_raw    = raw_bits;
            r.yaw_q7     = scaled[21:6];   // floor of scaled / 64
            r.good_count = good_cnt;
            pending_frames.push_back(r);
            frames_predicted++;
        endfunction

        function void check_frame(frame_result_t act);
            frame_result_t exp_r;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d yaw_raw=%0d q7=%0d count=%0d",
                         $time, act.status, act.yaw_raw, act.yaw_q7, act.good_count);
                errors++;
                return;
            end
            exp_r = pending_frames.pop_front();
            if (act.status !== exp_r.status)
            begin
                $display("%0t: frame_status expected %0d actual %0d",
                         $time, exp_r.status, act.status);
                errors++;
            end
            if (act.yaw_raw !== exp_r.yaw_raw)
            begin
                $display("%0t: yaw_raw expected %0d actual %0d",
                         $time, exp_r.yaw_raw, act.yaw_raw);
                errors++;
            end
            if (act.yaw_q7 !== exp_r.yaw_q7)
            begin
                $display("%0t: yaw_degrees_q7 expected %0d actual %0d",
                         $time, exp_r.yaw_q7, act.yaw_q7);
                errors++;
            end
            if (act.good_count !== exp_r.good_count)
            begin
                $display("%0t: good_frame_count expected %0d actual %0d",
                         $time, exp_r.good_count, act.good_count);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    imu_afp_byte_if rx_if ();
    imu_afp_cfg_if  cfg_if ();
    imu_afp_res_if  res_if ();

    imu_angle_frame_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    frame_checker checker_h;
    bit           idle_on;      // random gaps and stalls allowed
    int           bytes_sent;
    int           quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Result side: check each result transfer, then choose ready for the
    // next cycle. Ready is sampled and driven once per edge only.
    always @(posedge clk)
    begin
        frame_result_t act;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            act.status     = res_if.frame_status;
            act.yaw_raw    = res_if.yaw_raw;
            act.yaw_q7     = res_if.yaw_degrees_q7;
            act.good_count = res_if.good_frame_count;
            checker_h.check_frame(act);
        end
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (idle_on && $urandom_range(99) < IDLE_PCT)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= 1'b1;
    end

    // Watchdog: counts cycles with no transfer on any channel.
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (cfg_if.valid && cfg_if.ready)
            || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One byte transfer. Valid is left high on return so back-to-back
    // bytes never see a low/high pair of assignments in one step; the
    // gap loop lowers it, and so does drain_parser at the end of a stretch.
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        checker_h.note_byte(b);
        bytes_sent++;
    endtask

    // Builds and sends one 11-byte frame; the checksum is made right
    // unless bad_sum, and hdr_inside plants a header byte in the payload.
    task automatic send_frame(input logic [7:0] type_b, input logic [15:0] yaw,
                              input bit bad_sum, input bit hdr_inside);
        logic [7:0] fr [FRAME_BYTES];
        logic [7:0] s;
        fr[0] = HEADER_BYTE;
        fr[1] = type_b;
        for (int i = 2; i < FRAME_BYTES - 1; i++)
            fr[i] = 8'($urandom);
        if (hdr_inside)
            fr[$urandom_range(5, 2)] = HEADER_BYTE;
        fr[YAW_LOW_POS]  = yaw[7:0];
        fr[YAW_HIGH_POS] = yaw[15:8];
        s = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            s = s + fr[i];
        fr[SUM_POS] = bad_sum ? (s ^ 8'($urandom_range(255, 1))) : s;
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(fr[i]);
    endtask

    // Yaw mix: the signed extremes, zero and -1 show up often.
    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Finishes any partial frame, drops valid, and waits until every
    // predicted result has come out and the result stage has drained.
    task automatic drain_parser();
        while (checker_h.pos != IDLE_POS)
            send_byte(8'($urandom));
        rx_if.valid <= 1'b0;
        while (checker_h.frames_outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_angle_type(input logic [7:0] t);
        cfg_if.valid            <= 1'b1;
        cfg_if.angle_frame_type <= t;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        checker_h.set_angle_type(t);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One stretch of random traffic under the current type register.
    task automatic run_phase();
        int start_bytes;
        int start_frames;
        int pick;
        start_bytes  = bytes_sent;
        start_frames = checker_h.frames_predicted;
        while (bytes_sent - start_bytes < PHASE_BYTES
               || checker_h.frames_predicted - start_frames < PHASE_FRAMES)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                // well-formed frame, random content
                send_frame(checker_h.angle_type, pick_yaw(), 1'b0, $urandom_range(7) == 0);
            else if (pick < 72)
                // wrong type; sometimes the sum is bad too
                send_frame(checker_h.angle_type ^ 8'($urandom_range(255, 1)), pick_yaw(),
                           1'($urandom_range(1)), 1'b0);
            else if (pick < 80)
                send_frame(checker_h.angle_type, pick_yaw(), 1'b1, 1'b0);
            else if (pick < 90)
            begin
                // line noise; a stray header just starts a frame
                repeat ($urandom_range(3, 1))
                    send_byte(8'($urandom));
            end
            else
            begin
                // truncated frame: the next header lands mid-frame as data
                send_byte(HEADER_BYTE);
                repeat ($urandom_range(9, 1))
                    send_byte(8'($urandom));
            end
        end
        drain_parser();
    endtask

    initial
    begin
        checker_h               = new();
        idle_on                 = 1'b1;
        bytes_sent              = 0;
        rst_n                   = 1'b0;
        rx_if.valid             = 1'b0;
        rx_if.rx_byte           = 8'h00;
        cfg_if.valid            = 1'b0;
        cfg_if.angle_frame_type = 8'h00;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise while idle, then a good frame at the reset type
        // with a negative full-scale yaw and a header inside the payload,
        // then a frame failing both the type and the checksum.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(ANGLE_TYPE_RESET, 16'h8000, 1'b0, 1'b1);
        send_frame(8'h00, 16'h7FFF, 1'b1, 1'b0);
        drain_parser();

        // Random phases over several type settings, extremes included.
        run_phase();
        write_angle_type(8'h00);
        run_phase();
        idle_on = 1'b0;          // long stretch at full rate on both sides
        write_angle_type(8'hFF);
        run_phase();
        idle_on = 1'b1;
        write_angle_type(8'($urandom));
        run_phase();
        write_angle_type(ANGLE_TYPE_RESET);
        run_phase();

        // drain_parser already waited out the last result and the settle
        if (checker_h.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : tb
